// File: rtl/wpla_pkg.sv
`timescale 1ns / 1ps

package wpla_pkg;

    // Width and reset value of the window length register.
    localparam int WIN_BITS = 9;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 9'd16;

    // Defaults for the top-level parameters.
    localparam int MAX_WINDOW_DEF = 256;
    localparam int TIME_BITS_DEF  = 48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the packet report and read the oldest latency
        logic sub;       // remove the oldest latency from the sum when the ring is full
        logic add;       // add the new latency, write the ring, arm the divider
        logic div_step;  // one quotient bit of the average
        logic out_load;  // move the quotient into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reached;   // reached flag of the offered packet report
        logic div_last;  // the current divider step yields the last quotient bit
        logic out_free;  // the output register can take a new result
    } t_status;

endpackage

// File: rtl/wpla_ctrl.sv
`timescale 1ns / 1ps

module wpla_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  wpla_pkg::t_status i_status,
    output logic              o_in_ready,
    output wpla_pkg::t_cmd    o_cmd
);
    import wpla_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUB  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                // A report that did not arrive is taken and dropped here.
                if (i_in_valid && i_status.reached) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SUB;
                end
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/wpla_dpath.sv
`timescale 1ns / 1ps

module wpla_dpath #(
    parameter int MAX_WINDOW = wpla_pkg::MAX_WINDOW_DEF,
    parameter int TIME_BITS  = wpla_pkg::TIME_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [wpla_pkg::WIN_BITS-1:0]        i_cfg_wr_data,
    input  logic [TIME_BITS-1:0]                 i_entry_time,
    input  logic [TIME_BITS-1:0]                 i_exit_time,
    input  logic                                 i_reached,
    input  logic                                 i_out_ready,
    input  wpla_pkg::t_cmd                       i_cmd,
    output wpla_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    output logic [TIME_BITS-1:0]                 o_sample_time,
    output logic [TIME_BITS-1:0]                 o_average_latency
);
    import wpla_pkg::*;

    localparam int PTR_W    = $clog2(MAX_WINDOW);
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS = TIME_BITS + PTR_W;
    localparam int STEP_W   = $clog2(SUM_BITS + 1);

    logic [TIME_BITS-1:0] r_ring [MAX_WINDOW];
    logic [TIME_BITS-1:0] r_old;

    logic [WIN_BITS-1:0]  r_win;
    logic [SUM_BITS-1:0]  r_sum;
    logic [CNT_W-1:0]     r_fill;
    logic [PTR_W-1:0]     r_ptr;
    logic [TIME_BITS-1:0] r_lat;
    logic [TIME_BITS-1:0] r_exit;

    logic [SUM_BITS-1:0]  r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [STEP_W-1:0]    r_step;

    logic                 r_out_valid;
    logic [TIME_BITS-1:0] r_out_time;
    logic [TIME_BITS-1:0] r_out_avg;

    logic [CNT_W-1:0]     eff_win;
    logic                 full;
    logic [SUM_BITS-1:0]  n_sum_add;
    logic [PTR_W-1:0]     n_ptr;
    logic [CNT_W:0]       trial;
    logic                 take;

    // A window of zero acts as one, a window above the ring depth as the depth.
    always_comb begin
        if (r_win == '0) begin
            eff_win = CNT_W'(1);
        end else if (32'(r_win) > MAX_WINDOW) begin
            eff_win = CNT_W'(MAX_WINDOW);
        end else begin
            eff_win = CNT_W'(r_win);
        end
    end

    assign full      = (r_fill >= eff_win);
    assign n_sum_add = r_sum + SUM_BITS'(r_lat);
    assign n_ptr     = (32'(r_ptr) + 1 >= 32'(eff_win)) ? '0 : r_ptr + PTR_W'(1);

    // Restoring division, one quotient bit per step.
    assign trial = {r_rem, r_quo[SUM_BITS-1]};
    assign take  = (trial >= {1'b0, r_fill});

    assign o_status.reached  = i_reached;
    assign o_status.div_last = (r_step == STEP_W'(1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_old <= r_ring[r_ptr];
        end
        if (i_cmd.add) begin
            r_ring[r_ptr] <= r_lat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lat  <= (i_exit_time > i_entry_time) ? i_exit_time - i_entry_time : '0;
            r_exit <= i_exit_time;
        end
        if (i_cmd.add) begin
            r_quo <= n_sum_add;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_BITS-2:0], take};
            r_rem <= take ? CNT_W'(trial - {1'b0, r_fill}) : trial[CNT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_time <= r_exit;
            r_out_avg  <= r_quo[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= WIN_RESET;
            r_sum       <= '0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_win  <= i_cfg_wr_data;
                r_sum  <= '0;
                r_fill <= '0;
                r_ptr  <= '0;
            end else begin
                if (i_cmd.sub && full) begin
                    r_sum <= r_sum - SUM_BITS'(r_old);
                end
                if (i_cmd.add) begin
                    r_sum <= n_sum_add;
                    r_ptr <= n_ptr;
                    if (!full) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                end
            end
            if (i_cmd.add) begin
                r_step <= STEP_W'(SUM_BITS);
            end else if (i_cmd.div_step) begin
                r_step <= r_step - STEP_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sample_time     = r_out_time;
    assign o_average_latency = r_out_avg;

endmodule

// File: rtl/windowed_packet_latency_average_top.sv
`timescale 1ns / 1ps

// Windowed packet latency average.
// Packet reports arrive on the slave stream: tdata carries the entry and exit
// times, tuser the reached flag. A report whose packet did not arrive is taken
// and yields nothing. For an arrived packet the latency (exit minus
// entry, zero if negative) enters a ring of the last window_length latencies,
// and the master stream returns the exit time with the truncated mean of the
// latencies held; during warm-up the mean is over those seen so far.
// Each arrived packet passes through these steps in turn: one to take the
// transaction and read the oldest latency from the ring, two to update the
// running sum, one cycle per quotient bit in the restoring divider, and one to
// load the output register once that register is free.
// The next transaction is accepted as soon as the result sits in the output
// register, so a stalled receiver holds up the block only if a second result
// is ready before the first has been taken.
// Reset sets the window to 16 and empties the history; writing the window
// register through the configuration port also empties it. Ring contents need
// no clearing, as only entries written since the last clear are read.
module windowed_packet_latency_average_top #(
    parameter int MAX_WINDOW = wpla_pkg::MAX_WINDOW_DEF,
    parameter int TIME_BITS  = wpla_pkg::TIME_BITS_DEF,
    parameter int DATA_W     = ((2 * TIME_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Window length register.
    input  logic                          i_cfg_wr_en,
    input  logic [wpla_pkg::WIN_BITS-1:0] i_cfg_wr_data,
    // Packet reports.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [DATA_W-1:0]             s_axis_tdata,   // entry_time, exit_time, zero pad
    input  logic                          s_axis_tuser,   // reached
    // Averages.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [DATA_W-1:0]             m_axis_tdata    // sample_time, average_latency, zero pad
);
    import wpla_pkg::*;

    t_cmd                 cmd;
    t_status              status;
    logic [TIME_BITS-1:0] sample_time;
    logic [TIME_BITS-1:0] average_latency;

    // The controller sequences one arrived packet at a time.
    wpla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // The datapath holds the ring, the running sum, the divider and the output.
    wpla_dpath #(
        .MAX_WINDOW (MAX_WINDOW),
        .TIME_BITS  (TIME_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_entry_time      (s_axis_tdata[TIME_BITS-1:0]),
        .i_exit_time       (s_axis_tdata[2*TIME_BITS-1:TIME_BITS]),
        .i_reached         (s_axis_tuser),
        .i_out_ready       (m_axis_tready),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_out_valid       (m_axis_tvalid),
        .o_sample_time     (sample_time),
        .o_average_latency (average_latency)
    );

    assign m_axis_tdata = DATA_W'({average_latency, sample_time});

endmodule

// File: test/latency_average_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams, keeps its own copy of the
// latency window and checks every average that leaves the block.
module latency_average_checker #(
    parameter int TIME_BITS  = wpla_pkg::TIME_BITS_DEF,
    parameter int MAX_WINDOW = wpla_pkg::MAX_WINDOW_DEF,
    parameter int DATA_W     = 96
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [wpla_pkg::WIN_BITS-1:0] i_cfg_wr_data,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [DATA_W-1:0]             i_s_tdata,   // entry_time, exit_time
    input  logic                          i_s_tuser,   // reached
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [DATA_W-1:0]             i_m_tdata,   // sample_time, average_latency
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_reports,
    output int                            o_arrived,
    output int                            o_checked
);

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        t_time average;
        t_time sample;
    } t_average;

    localparam int MAX_REPORTS = 10;

    // Model state.
    t_time                      latency_ring [MAX_WINDOW];
    logic [TIME_BITS+7:0]       latency_total = '0;
    int unsigned                held_count    = 0;
    int unsigned                next_slot     = 0;
    logic [wpla_pkg::WIN_BITS-1:0] window_reg = wpla_pkg::WIN_RESET;

    t_average expected_averages [$];

    int fail_count = 0;
    int reports    = 0;
    int arrived    = 0;
    int checked    = 0;

    assign o_fail_count = fail_count;
    assign o_reports    = reports;
    assign o_arrived    = arrived;
    assign o_checked    = checked;

    function automatic void clear_window();
        latency_total = '0;
        held_count    = 0;
        next_slot     = 0;
    endfunction

    // Update the window with one arrived packet and return the average it yields.
    function automatic t_average predict_average(input t_time entry_t, input t_time exit_t);
        int unsigned span;
        int unsigned slot;
        t_time       latency;
        t_average    result;
        span = window_reg;
        if (span < 1) begin
            span = 1;
        end
        if (span > MAX_WINDOW) begin
            span = MAX_WINDOW;
        end
        latency = (exit_t > entry_t) ? exit_t - entry_t : '0;
        if (next_slot >= span) begin
            next_slot = 0;
        end
        slot = next_slot;
        if (held_count >= span) begin
            latency_total = latency_total - latency_ring[slot];
            held_count    = span;
        end else begin
            held_count++;
        end
        latency_ring[slot] = latency;
        latency_total      = latency_total + latency;
        next_slot          = slot + 1;
        if (next_slot >= span) begin
            next_slot = 0;
        end
        result.sample  = exit_t;
        result.average = t_time'(latency_total / (TIME_BITS+8)'(held_count));
        return result;
    endfunction

    always @(posedge i_clk) begin
        t_average want;
        t_average got;
        if (!i_rst_n) begin
            window_reg = wpla_pkg::WIN_RESET;
            clear_window();
            expected_averages.delete();
        end else begin
            if (i_cfg_wr_en) begin
                window_reg = i_cfg_wr_data;
                clear_window();
            end
            if (i_m_tvalid && i_m_tready) begin
                got.sample  = i_m_tdata[TIME_BITS-1:0];
                got.average = i_m_tdata[2*TIME_BITS-1:TIME_BITS];
                if (expected_averages.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected average: sample_time %0d average %0d",
                                 $realtime, got.sample, got.average);
                    end
                end else begin
                    want = expected_averages.pop_front();
                    checked++;
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display({"%0t: average mismatch: sample_time exp %0d got %0d, ",
                                      "average_latency exp %0d got %0d"},
                                     $realtime, want.sample, got.sample,
                                     want.average, got.average);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                reports++;
                if (i_s_tuser) begin
                    arrived++;
                    expected_averages.insert(expected_averages.size(),
                        predict_average(i_s_tdata[TIME_BITS-1:0],
                                        i_s_tdata[2*TIME_BITS-1:TIME_BITS]));
                end
            end
        end
        o_pending <= expected_averages.size();
    end

endmodule

// File: test/tb_windowed_packet_latency_average_top.sv
`timescale 1ns / 1ps

// Drives packet reports and window settings into the block, stalls the
// averages stream at random and gives the verdict from the checker's count.
module tb_windowed_packet_latency_average_top;

    localparam int TIME_BITS    = wpla_pkg::TIME_BITS_DEF;
    localparam int MAX_WINDOW   = wpla_pkg::MAX_WINDOW_DEF;
    localparam int DATA_W       = ((2 * TIME_BITS + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 80;       // a little more than one average's latency
    localparam int HOLD_CYCLES  = 400;      // long receiver stall to back the block up
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_PHASES   = 8;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef logic [TIME_BITS-1:0] t_time;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_wr_en   = 1'b0;
    logic [wpla_pkg::WIN_BITS-1:0] i_cfg_wr_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [DATA_W-1:0]             s_axis_tdata  = '0;   // entry_time, exit_time
    logic                          s_axis_tuser  = 1'b0; // reached
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [DATA_W-1:0]             m_axis_tdata;         // sample_time, average_latency

    int fail_count;
    int pending;
    int reports;
    int arrived;
    int checked;

    int tx_idle_pct   = 31;
    int rx_idle_pct   = 46;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    always #5 i_clk = ~i_clk;

    windowed_packet_latency_average_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    latency_average_checker #(
        .TIME_BITS  (TIME_BITS),
        .MAX_WINDOW (MAX_WINDOW),
        .DATA_W     (DATA_W)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_reports     (reports),
        .o_arrived     (arrived),
        .o_checked     (checked)
    );

    // The receiver either serves a requested long hold-off or stalls at random.
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("windowed_packet_latency_average_top test failed");
            $finish;
        end
    end

    function automatic t_time random_time();
        return t_time'({$urandom(), $urandom()});
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction,
    // leaving tvalid high so that back-to-back transactions need no gap.
    task automatic send_report(input t_time entry_t, input t_time exit_t, input logic reached);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'({exit_t, entry_t});
        s_axis_tuser  <= reached;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Mostly plausible latencies, with negative, random and huge spans mixed in.
    task automatic send_random_report();
        t_time entry_t;
        t_time exit_t;
        int    pick;
        pick    = $urandom_range(99);
        entry_t = random_time();
        if (pick < 55) begin
            exit_t = entry_t + t_time'($urandom_range(2000));
        end else if (pick < 70) begin
            exit_t = entry_t - t_time'($urandom_range(5000, 1));
        end else if (pick < 82) begin
            exit_t = random_time();
        end else if (pick < 92) begin
            entry_t = t_time'($urandom_range(1000));
            exit_t  = TIME_MAX - t_time'($urandom_range(1000));
        end else begin
            exit_t = entry_t;
        end
        send_report(entry_t, exit_t, $urandom_range(99) < 85);
    endtask

    // The window may only change once the block has gone quiet: every average
    // taken, and enough further cycles for a report still in flight to settle.
    task automatic write_window(input logic [wpla_pkg::WIN_BITS-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [wpla_pkg::WIN_BITS-1:0] phase_window [NUM_PHASES];
        int                            phase_items  [NUM_PHASES];
        int                            settings;

        // Zero, one, the largest window, values above it and a few in between.
        phase_window = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd3, 9'd0, 9'd257, 9'd2};
        phase_items  = '{150, 100, 400, 350, 150, 200, 150, 200};
        settings     = 1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset window of sixteen.
        send_report('0, '0, 1'b1);
        send_report('0, TIME_MAX, 1'b1);
        send_report(TIME_MAX, '0, 1'b1);
        send_report(TIME_MAX, TIME_MAX, 1'b1);
        send_report(t_time'(5), t_time'(10), 1'b0);
        send_report(TIME_MAX - 1, TIME_MAX, 1'b1);
        send_report(random_time(), random_time(), 1'b0);
        send_report({(TIME_BITS/2){2'b01}}, {(TIME_BITS/2){2'b10}}, 1'b1);
        for (int i = 0; i < 16; i++) begin
            send_report(t_time'(i * 1000), t_time'(i * 1037 + 1), (i % 5) != 4);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                tx_idle_pct = 46;
                rx_idle_pct = 31;
            end else if (p == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 5) begin
                write_window(9'($urandom_range(255, 4)));
            end else begin
                write_window(phase_window[p]);
            end
            settings++;
            // Back the block up at least once with and once without idling.
            if (p == 2 || p == 6) begin
                hold_requests++;
            end
            for (int n = 0; n < phase_items[p]; n++) begin
                send_random_report();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d packet reports (%0d arrived) over %0d window settings;",
                 reports, arrived, settings);
        $display("checked %0d averages, with zero, oversized and full windows wrapped.",
                 checked);
        if (fail_count == 0) begin
            $display("windowed_packet_latency_average_top test passed");
        end else begin
            $display("windowed_packet_latency_average_top test failed");
        end
        $finish;
    end

endmodule
